/* rtl/core/rlew_word_decompressor_assert.svh */
// assertion macros for the rlew word decompressor checker
`ifndef RLEW_WORD_DECOMPRESSOR_ASSERT_SVH
`define RLEW_WORD_DECOMPRESSOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define RLEW_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rlew check failed");

// next-cycle implication, checked outside reset
`define RLEW_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rlew check failed");

`endif

/* rtl/core/rlew_pkg.sv */
// shared types and constants of the rlew word decompressor
`default_nettype none
package rlew_pkg;

  localparam int unsigned WordW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned ProducedW = 17;
  localparam int unsigned CfgIdxW   = 1;

  typedef logic [WordW-1:0]     word_t;
  typedef logic [ByteW-1:0]     byte_t;
  typedef logic [ProducedW-1:0] produced_t;
  typedef logic [WordW-2:0]     final_t;
  typedef logic [CfgIdxW-1:0]   cfg_idx_t;

  // configuration register indexes
  localparam cfg_idx_t CfgRunKey       = 1'b0;
  localparam cfg_idx_t CfgLittleEndian = 1'b1;

  localparam word_t     RunKeyReset = 16'hFEFE;
  localparam produced_t ProducedMax = {ProducedW{1'b1}};

  // pair two stream bytes into a word in the configured byte order
  function automatic word_t join_bytes(input byte_t first, input byte_t second,
                                       input logic little_endian);
    word_t w;
    if (little_endian) begin
      w = {second, first};
    end else begin
      w = {first, second};
    end
    return w;
  endfunction

endpackage
`default_nettype wire

/* rtl/core/rlew_word_decompressor.sv */
// rlew word decompressor: byte stream in, run descriptors out
//
// input channel: one compressed byte per transaction (data_byte_i), with
// stream_start_i set on the first header byte of a new file. the first two
// bytes give the final length in bytes; the rest pair into words, and a word
// equal to run_key opens a (key, count, value) triple.
// output channel: one run descriptor per transaction (word_value_o,
// repeat_count_o, last_run_o); plain words carry a repeat count of one.
// output: a descriptor is registered and shown in the cycle after the byte that completes it.
// throughput: one byte per cycle, set by the single output register; a new
// byte is taken whenever the output register is empty or being drained.
// a stalled receiver holds the descriptor and, with it, the input channel.
// reset: first header byte expected, run key 0xfefe, big-endian, output empty.
// configuration: cfg_we_i writes register cfg_index_i (0 run key, 1 endian); the user must write
// only while no transaction is in flight, as the block itself does not enforce it.
`default_nettype none
module rlew_word_decompressor (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire rlew_pkg::byte_t   data_byte_i,
  input  wire logic              stream_start_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output rlew_pkg::word_t        word_value_o,
  output rlew_pkg::word_t        repeat_count_o,
  output logic                   last_run_o,
  input  wire logic              cfg_we_i,
  input  wire rlew_pkg::cfg_idx_t cfg_index_i,
  input  wire rlew_pkg::word_t   cfg_wdata_i
);
  import rlew_pkg::*;

  localparam logic [2:0] PhHdr0  = 3'd0;
  localparam logic [2:0] PhHdr1  = 3'd1;
  localparam logic [2:0] PhWord0 = 3'd2;
  localparam logic [2:0] PhWord1 = 3'd3;
  localparam logic [2:0] PhCnt0  = 3'd4;
  localparam logic [2:0] PhCnt1  = 3'd5;
  localparam logic [2:0] PhVal0  = 3'd6;
  localparam logic [2:0] PhVal1  = 3'd7;

  word_t       run_key_q;
  logic        little_endian_q;

  logic [2:0]  phase_q, phase_d;
  byte_t       held_byte_q, held_byte_d;
  final_t      final_words_q, final_words_d;
  produced_t   produced_q, produced_d;
  word_t       run_length_q, run_length_d;
  logic        finished_q, finished_d;

  logic        out_valid_q;
  word_t       word_value_q;
  word_t       repeat_count_q;
  logic        last_run_q;

  logic        in_fire;
  logic        emit;
  word_t       emit_value;
  word_t       emit_count;
  logic        emit_last;
  word_t       joined;
  produced_t   produced_base;
  logic [ProducedW:0] produced_sum;
  produced_t   produced_sat;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;
  assign joined     = join_bytes(held_byte_q, data_byte_i, little_endian_q);

  // running total, cleared by a start mark or the header
  assign produced_sum = {1'b0, produced_base} + {{(ProducedW + 1 - WordW){1'b0}}, emit_count};
  assign produced_sat = produced_sum[ProducedW] ? ProducedMax : produced_sum[ProducedW-1:0];

  always_comb begin
    phase_d       = phase_q;
    held_byte_d   = held_byte_q;
    final_words_d = final_words_q;
    produced_base = produced_q;
    run_length_d  = run_length_q;
    finished_d    = finished_q;
    emit          = 1'b0;
    emit_value    = joined;
    emit_count    = 16'd1;
    produced_d    = produced_q;
    emit_last     = 1'b0;
    if (in_fire && (stream_start_i || !finished_q)) begin
      if (stream_start_i) begin
        phase_d       = PhHdr0;
        produced_base = '0;
        run_length_d  = '0;
        finished_d    = 1'b0;
      end
      unique case (stream_start_i ? PhHdr0 : phase_q)
        PhHdr0, PhWord0, PhCnt0, PhVal0: begin
          held_byte_d = data_byte_i;
          phase_d     = (stream_start_i ? PhHdr0 : phase_q) + 3'd1;
        end
        PhHdr1: begin
          final_words_d = joined[WordW-1:1];
          produced_base = '0;
          phase_d       = PhWord0;
          finished_d    = (joined[WordW-1:1] == '0);
        end
        PhWord1: begin
          if (joined == run_key_q) begin
            phase_d = PhCnt0;
          end else begin
            phase_d = PhWord0;
            emit    = 1'b1;
          end
        end
        PhCnt1: begin
          run_length_d = joined;
          phase_d      = PhVal0;
        end
        PhVal1: begin
          phase_d    = PhWord0;
          emit_count = run_length_q;
          emit       = (run_length_q != '0);
        end
      endcase
      produced_d = produced_base;
      if (emit) begin
        produced_d = produced_sat;
        emit_last  = (produced_sat >= {2'b00, final_words_q});
        finished_d = finished_d || emit_last;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_key_q       <= RunKeyReset;
      little_endian_q <= 1'b0;
      phase_q         <= PhHdr0;
      held_byte_q     <= '0;
      final_words_q   <= '0;
      produced_q      <= '0;
      run_length_q    <= '0;
      finished_q      <= 1'b0;
      out_valid_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CfgRunKey:       run_key_q       <= cfg_wdata_i;
          CfgLittleEndian: little_endian_q <= cfg_wdata_i[0];
        endcase
      end
      phase_q       <= phase_d;
      held_byte_q   <= held_byte_d;
      final_words_q <= final_words_d;
      produced_q    <= produced_d;
      run_length_q  <= run_length_d;
      finished_q    <= finished_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // descriptor payload, loaded only with a new transaction
  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_value_q   <= emit_value;
      repeat_count_q <= emit_count;
      last_run_q     <= emit_last;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign word_value_o   = word_value_q;
  assign repeat_count_o = repeat_count_q;
  assign last_run_o     = last_run_q;

endmodule
`default_nettype wire

/* rtl/core/rlew_checker.sv */
// port-level checker for the rlew word decompressor, with its bind
`default_nettype none
`include "rlew_word_decompressor_assert.svh"
module rlew_checker (
  input wire logic            clk_i,
  input wire logic            rst_ni,
  input wire logic            in_valid_i,
  input wire logic            in_ready_i,
  input wire logic            out_valid_i,
  input wire logic            out_ready_i,
  input wire rlew_pkg::word_t repeat_count_i
);
  import rlew_pkg::*;

  word_t zero_count;
  assign zero_count = '0;

  // a stalled descriptor stays on offer
  `RLEW_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  // an empty output register never blocks the input side
  `RLEW_ASSERT_NOW(a_ready_when_empty, !out_valid_i, in_ready_i)
  // a full, stalled output register blocks the input side
  `RLEW_ASSERT_NOW(a_block_when_stalled, out_valid_i && !out_ready_i, !in_ready_i)
  // descriptors never carry a zero repeat count
  `RLEW_ASSERT_NOW(a_count_nonzero, out_valid_i, repeat_count_i != zero_count)
  // a new descriptor follows an accepted byte
  `RLEW_ASSERT_NOW(a_out_after_in, $rose(out_valid_i), $past(in_valid_i && in_ready_i))

endmodule

bind rlew_word_decompressor rlew_checker u_rlew_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_i     (in_ready_o),
  .out_valid_i    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .repeat_count_i (repeat_count_o)
);
`default_nettype wire

/* sim/tb_rlew_word_decompressor.sv */
// testbench for the rlew word decompressor: directed and random files against a local decoder
`timescale 1ns / 100ps
module tb_rlew_word_decompressor;
  import rlew_pkg::*;

  localparam int ReadyAlways = 0;
  localparam int ReadyMostly = 1;
  localparam int ReadyRarely = 2;

  typedef enum logic [2:0] {
    HdrFirst, HdrSecond, WordFirst, WordSecond,
    CountFirst, CountSecond, ValueFirst, ValueSecond
  } dec_phase_e;

  typedef struct packed {
    word_t word;
    word_t copies;
    logic  last;
  } run_desc_t;

  logic     clk_i        = 1'b0;
  logic     rst_ni       = 1'b0;
  logic     in_valid     = 1'b0;
  byte_t    data_byte    = '0;
  logic     stream_start = 1'b0;
  logic     out_ready    = 1'b0;
  logic     cfg_we       = 1'b0;
  cfg_idx_t cfg_index    = CfgRunKey;
  word_t    cfg_wdata    = '0;
  logic     in_ready;
  logic     out_valid;
  word_t    word_value;
  word_t    repeat_count;
  logic     last_run;

  // local copy of the decoder state and its registers
  word_t      cfg_key         = RunKeyReset;
  logic       cfg_le          = 1'b0;
  dec_phase_e st_phase        = HdrFirst;
  byte_t      st_held         = '0;
  final_t     st_length_words = '0;
  produced_t  st_written      = '0;
  word_t      st_run_count    = '0;
  logic       st_done         = 1'b0;

  run_desc_t   pending_runs[$];
  int unsigned errors        = 0;
  int unsigned bytes_decoded = 0;
  int unsigned burst_left    = 0;
  int          ready_mode    = ReadyAlways;
  int unsigned ready_window  = 0;

  rlew_word_decompressor uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .data_byte_i    (data_byte),
    .stream_start_i (stream_start),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .word_value_o   (word_value),
    .repeat_count_o (repeat_count),
    .last_run_o     (last_run),
    .cfg_we_i       (cfg_we),
    .cfg_index_i    (cfg_index),
    .cfg_wdata_i    (cfg_wdata)
  );

  always #1 clk_i = ~clk_i;

  function automatic word_t pair_bytes(input byte_t first_b, input byte_t second_b);
    return cfg_le ? {second_b, first_b} : {first_b, second_b};
  endfunction

  function automatic void record_run(input word_t w, input word_t n);
    run_desc_t            d;
    logic [ProducedW:0]   total;
    total      = st_written + n;
    st_written = (total > ProducedMax) ? ProducedMax : total[ProducedW-1:0];
    d.word     = w;
    d.copies   = n;
    d.last     = (st_written >= st_length_words);
    if (d.last) st_done = 1'b1;
    pending_runs = {pending_runs, d};
  endfunction

  // returns 0 when the byte is dropped because the file is already complete
  function automatic bit decode_byte(input byte_t b, input logic start);
    word_t w;
    if (start) begin
      st_phase     = HdrFirst;
      st_written   = '0;
      st_run_count = '0;
      st_done      = 1'b0;
    end else if (st_done) begin
      return 1'b0;
    end
    w = pair_bytes(st_held, b);
    case (st_phase)
      HdrFirst, WordFirst, CountFirst, ValueFirst: begin
        st_held  = b;
        st_phase = dec_phase_e'(st_phase + 3'd1);
      end
      HdrSecond: begin
        st_length_words = w[WordW-1:1];
        st_written      = '0;
        st_phase        = WordFirst;
        if (st_length_words == '0) st_done = 1'b1;
      end
      WordSecond: begin
        if (w == cfg_key) begin
          st_phase = CountFirst;
        end else begin
          st_phase = WordFirst;
          record_run(w, 16'd1);
        end
      end
      CountSecond: begin
        st_run_count = w;
        st_phase     = ValueFirst;
      end
      default: begin
        st_phase = WordFirst;
        if (st_run_count != '0) record_run(w, st_run_count);
      end
    endcase
    return 1'b1;
  endfunction

  task automatic flag_error(input string what, input run_desc_t want, input run_desc_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected word %h copies %h last %b, got word %h copies %h last %b",
               what, want.word, want.copies, want.last, got.word, got.copies, got.last);
  endtask

  task automatic send_byte(input byte_t b, input logic start);
    int unsigned gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 8);
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid     <= 1'b1;
    data_byte    <= b;
    stream_start <= start;
    do @(posedge clk_i); while (!in_ready);
    if (decode_byte(b, start)) bytes_decoded++;
  endtask

  // byte order follows the endian register as currently set
  task automatic send_word(input word_t w, input logic start);
    if (cfg_le) begin
      send_byte(w[7:0], start);
      send_byte(w[15:8], 1'b0);
    end else begin
      send_byte(w[15:8], start);
      send_byte(w[7:0], 1'b0);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input word_t value);
    drain;
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == CfgRunKey) cfg_key = value;
    else cfg_le = value[0];
    @(posedge clk_i);
  endtask

  // no start mark: the first byte after reset still opens the header
  task automatic test_first_file;
    send_word(16'h0002, 1'b0);
    send_word(16'h0000, 1'b0);
    send_byte(8'hff, 1'b0);
  endtask

  // zero-count run, then a full-length run that overshoots the largest header
  task automatic test_runs;
    send_word(16'hffff, 1'b1);
    send_word(RunKeyReset, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h1234, 1'b0);
    send_word(RunKeyReset, 1'b0);
    send_word(16'hffff, 1'b0);
    send_word(16'hffff, 1'b0);
  endtask

  // empty file, ignored trailing byte, then a file cut off inside a word
  task automatic test_empty_and_truncated;
    send_word(16'h0001, 1'b1);
    send_byte(8'h3c, 1'b0);
    send_word(16'h0008, 1'b1);
    send_byte(8'h11, 1'b0);
  endtask

  // byte order switched between the two bytes of a word
  task automatic test_config_midword;
    write_reg(CfgRunKey, 16'h0000);
    write_reg(CfgLittleEndian, 16'h0001);
    send_word(16'h0002, 1'b1);
    send_byte(8'h34, 1'b0);
    write_reg(CfgLittleEndian, 16'h0000);
    send_byte(8'h12, 1'b0);
  endtask

  task automatic send_random_file;
    int unsigned words;
    int unsigned cut;
    int unsigned made;
    word_t       w;
    word_t       cnt;
    if ($urandom_range(0, 4) == 0) words = $urandom_range(0, 2);
    else words = $urandom_range(3, 40);
    cut = ($urandom_range(0, 7) == 0) ? $urandom_range(0, words) : words;
    send_word(word_t'(words * 2 + $urandom_range(0, 1)), $urandom_range(0, 15) != 0);
    made = 0;
    while (made < cut) begin
      if ($urandom_range(0, 4) == 0) begin
        case ($urandom_range(0, 7))
          0:       cnt = '0;
          1:       cnt = word_t'($urandom);
          default: cnt = word_t'($urandom_range(1, 6));
        endcase
        send_word(cfg_key, 1'b0);
        send_word(cnt, 1'b0);
        send_word(word_t'($urandom), 1'b0);
        made += cnt;
      end else begin
        w = word_t'($urandom);
        if (w == cfg_key) w = ~w;
        send_word(w, 1'b0);
        made++;
      end
    end
    // a truncated file may also stop halfway through a word
    if (cut < words && $urandom_range(0, 1) == 1) send_byte(byte_t'($urandom), 1'b0);
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3)) send_byte(byte_t'($urandom), 1'b0);
  endtask

  task automatic test_random_files;
    int unsigned target;
    word_t       key;
    target = bytes_decoded + 850;
    while (bytes_decoded < target) begin
      if ($urandom_range(0, 5) == 0) begin
        case ($urandom_range(0, 3))
          0:       key = 16'h0000;
          1:       key = 16'hffff;
          2:       key = RunKeyReset;
          default: key = word_t'($urandom);
        endcase
        write_reg(CfgRunKey, key);
        write_reg(CfgLittleEndian, word_t'($urandom_range(0, 1)));
      end
      send_random_file;
    end
  endtask

  // receiver stall pattern, picked anew at random whenever its window runs out
  always @(posedge clk_i) begin
    if (ready_window == 0) begin
      ready_mode   <= $urandom_range(ReadyAlways, ReadyRarely);
      ready_window <= $urandom_range(16, 80);
    end else begin
      ready_window <= ready_window - 1;
    end
    case (ready_mode)
      ReadyAlways: out_ready <= 1'b1;
      ReadyMostly: out_ready <= ($urandom_range(0, 3) != 0);
      default:     out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    run_desc_t got;
    run_desc_t want;
    if (rst_ni && out_valid && out_ready) begin
      got.word   = word_value;
      got.copies = repeat_count;
      got.last   = last_run;
      if (pending_runs.size() == 0) begin
        flag_error("no transaction expected", '0, got);
      end else begin
        want = pending_runs.pop_front();
        if (got.word !== want.word || got.copies !== want.copies || got.last !== want.last)
          flag_error("field mismatch", want, got);
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_first_file;
    test_runs;
    test_empty_and_truncated;
    test_config_midword;
    test_random_files;
    drain;
    repeat (8) @(posedge clk_i);
    if (errors == 0 && pending_runs.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #500000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
